// ===== src/assert_macros.svh =====
// Assertion helpers for the ready queue scheduler.
// Every check runs on clk_i and is held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define RQS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define RQS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/rqs_pkg.sv =====
package rqs_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned IdW        = 8;
  localparam int unsigned TimeW      = 16;
  localparam int unsigned PrioW      = 8;
  localparam int unsigned PolicyW    = 3;
  localparam int unsigned PaddrW     = 3;
  localparam int unsigned PdataW     = 32;

  // register select: paddr[2] (byte offset bits ignored)
  localparam logic REG_POLICY = 1'b0;

  localparam logic KIND_ENQ   = 1'b0;
  localparam logic KIND_SCHED = 1'b1;

  typedef enum logic [PolicyW-1:0] {
    POL_FIFO = 3'd0,
    POL_SJF  = 3'd1,
    POL_SRTF = 3'd2,
    POL_RR   = 3'd3,
    POL_PRIO = 3'd4
  } policy_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_PREP,
    ST_SHIFT,
    ST_POP,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic             kind;
    logic [IdW-1:0]   task_id;
    logic [TimeW-1:0] task_lifespan;
    logic [TimeW-1:0] task_age;
    logic [PrioW-1:0] task_prio;
    logic             running_valid;
    logic             running_waiting;
  } req_t;

  typedef struct packed {
    logic             next_valid;
    logic [IdW-1:0]   next_id;
    logic [TimeW-1:0] next_lifespan;
    logic [TimeW-1:0] next_age;
    logic [PrioW-1:0] next_prio;
    logic             overflow;
  } rsp_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] lifespan;
    logic [TimeW-1:0] age;
    logic [PrioW-1:0] prio;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic load;        // capture the accepted request
    logic append;      // write the held task at the tail
    logic sanitize;    // fold unknown policy codes to fifo
    logic scan_init;
    logic scan_rd;
    logic shift_init;
    logic shift_rd;
    logic pop;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic kind_sched;
    logic keep;        // running task unfinished and not waiting
    logic pol_keep;    // policy lets the running task stay on
    logic occ_zero;
    logic scan_last;
    logic shift_more;
    logic out_free;
  } ctrl_sts_t;

  function automatic policy_e pol_clean(policy_e p);
    policy_e r;
    case (p)
      POL_FIFO, POL_SJF, POL_SRTF, POL_RR, POL_PRIO: r = p;
      default: r = POL_FIFO;
    endcase
    return r;
  endfunction

  // Smaller key wins; strict compare keeps ties on the earliest entry.
  function automatic logic [TimeW-1:0] sort_key(policy_e p, entry_t e);
    logic [TimeW-1:0] k;
    case (p)
      POL_SJF:  k = e.lifespan;
      POL_SRTF: k = (e.age >= e.lifespan) ? '0 : e.lifespan - e.age;
      POL_PRIO: k = TimeW'(~e.prio);
      default:  k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== src/rqs_req_if.sv =====
interface rqs_req_if;
  logic          valid;
  logic          ready;
  rqs_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rqs_rsp_if.sv =====
interface rqs_rsp_if;
  logic          valid;
  logic          ready;
  rqs_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rqs_ram.sv =====
module rqs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rqs_ctrl.sv =====
module rqs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rqs_pkg::ctrl_sts_t    sts_i,
  output rqs_pkg::ctrl_cmd_t    cmd_o
);

  rqs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rqs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rqs_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rqs_pkg::ST_DECIDE;
      end
      rqs_pkg::ST_DECIDE: begin
        if (!sts_i.kind_sched || (sts_i.keep && sts_i.pol_keep)) begin
          state_d = rqs_pkg::ST_RESULT;
        end else begin
          state_d = rqs_pkg::ST_CHECK;
        end
      end
      rqs_pkg::ST_CHECK: begin
        state_d = sts_i.occ_zero ? rqs_pkg::ST_RESULT : rqs_pkg::ST_SCAN;
      end
      rqs_pkg::ST_SCAN: begin
        if (sts_i.scan_last) state_d = rqs_pkg::ST_SCAN_TAIL;
      end
      rqs_pkg::ST_SCAN_TAIL: state_d = rqs_pkg::ST_PREP;
      rqs_pkg::ST_PREP:      state_d = rqs_pkg::ST_SHIFT;
      rqs_pkg::ST_SHIFT: begin
        if (!sts_i.shift_more) state_d = rqs_pkg::ST_POP;
      end
      rqs_pkg::ST_POP: state_d = rqs_pkg::ST_RESULT;
      rqs_pkg::ST_RESULT: begin
        if (sts_i.out_free) state_d = rqs_pkg::ST_IDLE;
      end
      default: state_d = rqs_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rqs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rqs_pkg::ST_DECIDE: begin
        // enqueue, or re-append a preempted task
        cmd_o.append = !sts_i.kind_sched || (sts_i.keep && !sts_i.pol_keep);
      end
      rqs_pkg::ST_CHECK: begin
        cmd_o.sanitize  = !sts_i.occ_zero;
        cmd_o.scan_init = !sts_i.occ_zero;
      end
      rqs_pkg::ST_SCAN:      cmd_o.scan_rd    = 1'b1;
      rqs_pkg::ST_SCAN_TAIL: cmd_o            = '0;
      rqs_pkg::ST_PREP:      cmd_o.shift_init = 1'b1;
      rqs_pkg::ST_SHIFT:     cmd_o.shift_rd   = sts_i.shift_more;
      rqs_pkg::ST_POP:       cmd_o.pop        = 1'b1;
      rqs_pkg::ST_RESULT:    cmd_o.out_load   = sts_i.out_free;
      default:               cmd_o            = '0;
    endcase
  end

endmodule

// ===== src/rqs_datapath.sv =====
module rqs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rqs_pkg::ctrl_cmd_t            cmd_i,
  output rqs_pkg::ctrl_sts_t            sts_o,
  input  rqs_pkg::req_t                 req_data_i,
  input  logic                          cfg_we_i,
  input  logic [rqs_pkg::PolicyW-1:0]   cfg_wdata_i,
  output rqs_pkg::policy_e              policy_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output rqs_pkg::rsp_t                 rsp_data_o
);

  logic [rqs_pkg::CntW-1:0]  occ_q, occ_d;
  logic [rqs_pkg::CntW-1:0]  cnt_q, cnt_d;
  rqs_pkg::policy_e          policy_q, policy_d;
  logic                      cmp_vld_q, shf_vld_q;
  logic                      ovf_q, ovf_d;
  logic                      picked_q, picked_d;
  logic                      out_valid_q, out_valid_d;

  rqs_pkg::req_t             item_q;
  logic [rqs_pkg::IdxW-1:0]  ridx_q;
  logic [rqs_pkg::IdxW-1:0]  best_idx_q;
  logic [rqs_pkg::TimeW-1:0] best_key_q;
  rqs_pkg::entry_t           best_q;
  rqs_pkg::rsp_t             out_q, out_d;

  logic                       ram_we;
  logic [rqs_pkg::IdxW-1:0]   ram_waddr;
  logic [rqs_pkg::EntryW-1:0] ram_wdata;
  logic [rqs_pkg::EntryW-1:0] ram_rdata;
  rqs_pkg::entry_t            rd_entry;
  rqs_pkg::entry_t            item_entry;
  logic [rqs_pkg::TimeW-1:0]  rd_key;
  logic                       occ_full;
  logic                       keep;
  logic                       pol_keep;
  logic                       replace;

  assign occ_full   = (occ_q == rqs_pkg::CntW'(rqs_pkg::QueueDepth));
  assign keep       = item_q.running_valid && !item_q.running_waiting &&
                      (item_q.task_age < item_q.task_lifespan);
  assign pol_keep   = (rqs_pkg::pol_clean(policy_q) inside {rqs_pkg::POL_FIFO,
                                                            rqs_pkg::POL_SJF});
  assign item_entry = '{id: item_q.task_id, lifespan: item_q.task_lifespan,
                        age: item_q.task_age, prio: item_q.task_prio};
  assign rd_entry   = rqs_pkg::entry_t'(ram_rdata);
  assign rd_key     = rqs_pkg::sort_key(policy_q, rd_entry);
  assign replace    = (ridx_q == '0) || (rd_key < best_key_q);

  // table write port: tail append or compaction shift (never both)
  always_comb begin
    if (shf_vld_q) begin
      ram_we    = 1'b1;
      ram_waddr = ridx_q - rqs_pkg::IdxW'(1);
      ram_wdata = ram_rdata;
    end else begin
      ram_we    = cmd_i.append && !occ_full;
      ram_waddr = occ_q[rqs_pkg::IdxW-1:0];
      ram_wdata = item_entry;
    end
  end

  rqs_ram #(
    .Width (rqs_pkg::EntryW),
    .Depth (rqs_pkg::QueueDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[rqs_pkg::IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    occ_d       = occ_q;
    cnt_d       = cnt_q;
    policy_d    = policy_q;
    ovf_d       = ovf_q;
    picked_d    = picked_q;
    out_valid_d = out_valid_q;

    if (cfg_we_i) policy_d = rqs_pkg::policy_e'(cfg_wdata_i);
    if (cmd_i.sanitize) policy_d = rqs_pkg::pol_clean(policy_q);

    if (cmd_i.load) begin
      ovf_d    = 1'b0;
      picked_d = 1'b0;
    end
    if (cmd_i.append) begin
      if (occ_full) begin
        ovf_d = 1'b1;
      end else begin
        occ_d = occ_q + rqs_pkg::CntW'(1);
      end
    end
    if (cmd_i.scan_init) cnt_d = '0;
    if (cmd_i.shift_init) cnt_d = rqs_pkg::CntW'(best_idx_q) + rqs_pkg::CntW'(1);
    if (cmd_i.scan_rd || cmd_i.shift_rd) cnt_d = cnt_q + rqs_pkg::CntW'(1);
    if (cmd_i.pop) begin
      occ_d    = occ_q - rqs_pkg::CntW'(1);
      picked_d = 1'b1;
    end

    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // result word
  always_comb begin
    out_d = '0;
    if (item_q.kind == rqs_pkg::KIND_ENQ) begin
      out_d.overflow = ovf_q;
    end else if (keep && pol_keep) begin
      out_d.next_valid    = 1'b1;
      out_d.next_id       = item_q.task_id;
      out_d.next_lifespan = item_q.task_lifespan;
      out_d.next_age      = item_q.task_age;
      out_d.next_prio     = item_q.task_prio;
    end else if (picked_q) begin
      out_d.next_valid    = 1'b1;
      out_d.next_id       = best_q.id;
      out_d.next_lifespan = best_q.lifespan;
      out_d.next_age      = best_q.age;
      out_d.next_prio     = best_q.prio;
      out_d.overflow      = ovf_q;
    end else begin
      out_d.overflow = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      cnt_q       <= '0;
      policy_q    <= rqs_pkg::POL_FIFO;
      cmp_vld_q   <= 1'b0;
      shf_vld_q   <= 1'b0;
      ovf_q       <= 1'b0;
      picked_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      cnt_q       <= cnt_d;
      policy_q    <= policy_d;
      cmp_vld_q   <= cmd_i.scan_rd;
      shf_vld_q   <= cmd_i.shift_rd;
      ovf_q       <= ovf_d;
      picked_q    <= picked_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= cnt_q[rqs_pkg::IdxW-1:0];
    if (cmd_i.load) item_q <= req_data_i;
    if (cmp_vld_q && replace) begin
      best_idx_q <= ridx_q;
      best_key_q <= rd_key;
      best_q     <= rd_entry;
    end
    if (cmd_i.out_load) out_q <= out_d;
  end

  assign sts_o.kind_sched = (item_q.kind == rqs_pkg::KIND_SCHED);
  assign sts_o.keep       = keep;
  assign sts_o.pol_keep   = pol_keep;
  assign sts_o.occ_zero   = (occ_q == '0);
  assign sts_o.scan_last  = (cnt_q == occ_q - rqs_pkg::CntW'(1));
  assign sts_o.shift_more = (cnt_q < occ_q);
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;

  assign policy_o    = policy_q;
  assign rsp_valid_o = out_valid_q;
  assign rsp_data_o  = out_q;

endmodule

// ===== src/ready_queue_scheduler_top.sv =====
// Ready queue scheduler: one request in, one result out, one request at a time.
// Enqueue, or a decision that keeps the running task: goes from decide straight to result, with no table walk.
// Decision over n table entries (after any re-append): after check, the table RAM is walked in the scan
// and shift states (one scan read, then one shift per cycle), then the chosen entry is popped.
// Next request is taken the cycle after the result is registered (result may still wait).
// Reset (rst_ni low, async): empty table, policy fifo; table contents left undefined.
`include "assert_macros.svh"

module ready_queue_scheduler_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rqs_req_if.sink                      req_i,
  rqs_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rqs_pkg::PaddrW-1:0]   paddr,
  input  logic [rqs_pkg::PdataW-1:0]   pwdata,
  output logic [rqs_pkg::PdataW-1:0]   prdata,
  output logic                         pready
);

  rqs_pkg::ctrl_cmd_t cmd;
  rqs_pkg::ctrl_sts_t sts;
  rqs_pkg::policy_e   policy;
  logic               in_ready;
  logic               cfg_we;

  // APB: zero wait states; the policy register sits at byte address 0.
  // paddr[1:0] is the byte offset and is ignored.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == rqs_pkg::REG_POLICY);
  assign prdata = (paddr[2] == rqs_pkg::REG_POLICY) ? rqs_pkg::PdataW'(policy) : '0;

  assign req_i.ready = in_ready;

  // Controller: sequences append, scan, compaction and result load.
  rqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: table RAM, occupancy, best-entry tracker and output register.
  rqs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_data_i  (req_i.data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[rqs_pkg::PolicyW-1:0]),
    .policy_o    (policy),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_data_o  (rsp_o.data)
  );

  // Table port users must not overlap.
  `RQS_ASSERT(a_ram_users_excl, $onehot0({cmd.append, cmd.scan_rd, cmd.shift_rd}),
              "table append, scan and shift overlap")
  // While a request can be taken, no table walk is in flight.
  `RQS_ASSERT_IMPL(a_idle_no_walk, req_i.ready, !cmd.scan_rd && !cmd.shift_rd,
                   "request ready during table walk")
  // The result register is only loaded when it is free.
  `RQS_ASSERT_IMPL(a_load_free, cmd.out_load, sts.out_free,
                   "result loaded over a pending result")
  // A new result only shows up after a load command.
  `RQS_ASSERT(a_valid_from_load, $rose(rsp_o.valid) |-> $past(cmd.out_load),
              "result valid without load")

endmodule
